/* src/shfd_pkg.sv */
// Shared types, constants and CRC helpers for the sync-header frame deframer.
// No dependencies; every other file imports this package.
package shfd_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR  = 2'd1,
    PH_PAY  = 2'd2,
    PH_CRC  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PAYLOAD  = 3'd1,
    EV_GOOD     = 3'd2,
    EV_CRC_ERR  = 3'd3,
    EV_OVERSIZE = 3'd4
  } event_t;

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'h1021;
  localparam logic [31:0] SYNC_RESET        = 32'hAAAA5555;
  localparam logic [7:0]  MAX_PAYLOAD_RESET = 8'd250;

  localparam logic [1:0] FC_TYPE = 2'd0;
  localparam logic [1:0] FC_SEQ  = 2'd1;
  localparam logic [1:0] FC_LAST_SYNC = 2'd3;

  localparam logic REG_SYNC = 1'b0;
  localparam logic REG_MAX  = 1'b1;

  typedef struct packed {
    logic [31:0] sync_pattern;
    logic [7:0]  max_payload;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  frame_type;
    logic [7:0]  frame_seq;
    logic [7:0]  payload_len;
    logic [15:0] crc_calculated;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] sync_byte(input logic [31:0] pattern, input logic [1:0] k);
    logic [7:0] s;
    unique case (k)
      2'd0: s = pattern[31:24];
      2'd1: s = pattern[23:16];
      2'd2: s = pattern[15:8];
      default: s = pattern[7:0];
    endcase
    return s;
  endfunction

endpackage

/* src/sync_header_frame_deframer_crc16_core.sv */
// Top level of the sync-header frame deframer with CRC-16/CCITT-FALSE check.
// Depends on shfd_pkg, shfd_regs, shfd_in_stage, shfd_parse and shfd_out_stage.
//
// One received byte enters per item and exactly one result item leaves for each,
// in order. The block takes a new byte every clock cycle while the output side
// keeps up; a byte passes through an input register, the parse stage (one
// byte-wide CRC update plus the frame state machine) and a result register
// before its result is presented. A stalled output holds at most two items
// inside before the input stalls. Nothing needs clearing after reset: the first
// byte may follow reset at once.
module sync_header_frame_deframer_crc16_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] data_byte, [15:8] byte_index, [23:16] frame_type,
                                 // [31:24] frame_seq, [39:32] payload_len, [55:40] crc_calculated
  output logic [2:0]  m_tuser,   // [2:0] event_res
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import shfd_pkg::*;

  cfg_t    cfg;
  item_t   item;
  item_t   step;
  result_t res;
  result_t res_q;
  logic    advance;

  assign advance    = item.valid && (!m_tvalid || m_tready);
  assign step.valid = advance;
  assign step.rx_byte = item.rx_byte;

  shfd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  shfd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .item     (item)
  );

  shfd_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .item (step),
    .cfg  (cfg),
    .res  (res)
  );

  shfd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res      (res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .res_q    (res_q)
  );

  assign m_tuser = res_q.event_res;
  assign m_tdata = {res_q.crc_calculated, res_q.payload_len, res_q.frame_seq,
                    res_q.frame_type, res_q.byte_index, res_q.data_byte};

endmodule

/* src/shfd_regs.sv */
// APB-style configuration registers: sync pattern and maximum payload length.
// Depends on shfd_pkg.
module shfd_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output shfd_pkg::cfg_t      cfg
);
  import shfd_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_pattern <= SYNC_RESET;
      cfg.max_payload  <= MAX_PAYLOAD_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_SYNC: cfg.sync_pattern <= pwdata;
        default:  cfg.max_payload  <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SYNC: prdata = cfg.sync_pattern;
      default:  prdata = {24'd0, cfg.max_payload};
    endcase
    if (paddr[1:0] != 2'd0) begin
      prdata = cfg.sync_pattern & 32'd0;
    end
  end

endmodule

/* src/shfd_in_stage.sv */
// Input register: holds one received byte until the parse stage takes it.
// Depends on shfd_pkg.
module shfd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              advance,
  output shfd_pkg::item_t   item
);
  import shfd_pkg::*;

  assign s_tready = !item.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (s_tready) begin
      item.valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.rx_byte <= s_tdata;
    end
  end

endmodule

/* src/shfd_parse.sv */
// Frame parser: sync hunt, header capture, payload indexing and CRC check.
// Holds all frame state; result is combinational from state and the item. Depends on shfd_pkg.
module shfd_parse (
  input  logic               clk,
  input  logic               rst,
  input  shfd_pkg::item_t    item,
  input  shfd_pkg::cfg_t     cfg,
  output shfd_pkg::result_t  res
);
  import shfd_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  field_counter, field_counter_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  seq_reg, seq_reg_next;
  logic [7:0]  length_reg, length_reg_next;
  logic [7:0]  payload_counter, payload_counter_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  logic [7:0]  b;
  logic        sync_hit;
  logic        first_hit;
  logic [15:0] feed_base;
  logic [15:0] crc_step;
  event_t      ev;
  logic [7:0]  dat;
  logic [7:0]  idx;

  assign b         = item.rx_byte;
  assign sync_hit  = (b == sync_byte(cfg.sync_pattern, field_counter));
  assign first_hit = (b == sync_byte(cfg.sync_pattern, 2'd0));

  always_comb begin
    if (phase != PH_HUNT) begin
      feed_base = running_crc;
    end else if (sync_hit && field_counter != 2'd0) begin
      feed_base = running_crc;
    end else begin
      feed_base = CRC_INIT;
    end
  end

  assign crc_step = crc_feed(feed_base, b);

  always_comb begin
    phase_next           = phase;
    field_counter_next   = field_counter;
    type_reg_next        = type_reg;
    seq_reg_next         = seq_reg;
    length_reg_next      = length_reg;
    payload_counter_next = payload_counter;
    running_crc_next     = running_crc;
    crc_low_byte_next    = crc_low_byte;
    ev                   = EV_NONE;
    dat                  = 8'd0;
    idx                  = 8'd0;
    unique case (phase)
      PH_HUNT: begin
        if (sync_hit) begin
          running_crc_next = crc_step;
          if (field_counter == FC_LAST_SYNC) begin
            field_counter_next = 2'd0;
            phase_next         = PH_HDR;
          end else begin
            field_counter_next = field_counter + 2'd1;
          end
        end else if (first_hit) begin
          running_crc_next   = crc_step;
          field_counter_next = 2'd1;
        end else begin
          running_crc_next   = CRC_INIT;
          field_counter_next = 2'd0;
        end
      end
      PH_HDR: begin
        running_crc_next = crc_step;
        priority if (field_counter == FC_TYPE) begin
          type_reg_next      = b;
          field_counter_next = 2'd1;
        end else if (field_counter == FC_SEQ) begin
          seq_reg_next       = b;
          field_counter_next = 2'd2;
        end else begin
          length_reg_next      = b;
          field_counter_next   = 2'd0;
          payload_counter_next = 8'd0;
          priority if (b > cfg.max_payload) begin
            ev               = EV_OVERSIZE;
            phase_next       = PH_HUNT;
            running_crc_next = CRC_INIT;
          end else if (b == 8'd0) begin
            phase_next = PH_CRC;
          end else begin
            phase_next = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        running_crc_next     = crc_step;
        ev                   = EV_PAYLOAD;
        dat                  = b;
        idx                  = payload_counter;
        payload_counter_next = payload_counter + 8'd1;
        if (payload_counter_next >= length_reg || payload_counter_next == 8'd0) begin
          phase_next         = PH_CRC;
          field_counter_next = 2'd0;
        end
      end
      PH_CRC: begin
        if (field_counter == 2'd0) begin
          crc_low_byte_next  = b;
          field_counter_next = 2'd1;
        end else begin
          ev                 = ({b, crc_low_byte} == running_crc) ? EV_GOOD : EV_CRC_ERR;
          phase_next         = PH_HUNT;
          field_counter_next = 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      field_counter   <= 2'd0;
      type_reg        <= 8'd0;
      seq_reg         <= 8'd0;
      length_reg      <= 8'd0;
      payload_counter <= 8'd0;
      running_crc     <= CRC_INIT;
      crc_low_byte    <= 8'd0;
    end else if (item.valid) begin
      phase           <= phase_next;
      field_counter   <= field_counter_next;
      type_reg        <= type_reg_next;
      seq_reg         <= seq_reg_next;
      length_reg      <= length_reg_next;
      payload_counter <= payload_counter_next;
      running_crc     <= running_crc_next;
      crc_low_byte    <= crc_low_byte_next;
    end
  end

  assign res.event_res      = ev;
  assign res.data_byte      = dat;
  assign res.byte_index     = idx;
  assign res.frame_type     = type_reg_next;
  assign res.frame_seq      = seq_reg_next;
  assign res.payload_len    = length_reg_next;
  assign res.crc_calculated = running_crc_next;

`ifndef ASSERT_OFF
  a_pay_len: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAY |-> (length_reg != 8'd0 && payload_counter < length_reg))
    else $error("payload phase with counter outside length");
  a_hdr_fc: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HDR |-> field_counter != FC_LAST_SYNC)
    else $error("header field counter out of range");
  a_oversize: assert property (@(posedge clk) disable iff (rst)
    item.valid && ev == EV_OVERSIZE |=> phase == PH_HUNT && running_crc == CRC_INIT)
    else $error("oversize length did not return to hunt");
  a_crc_hold: assert property (@(posedge clk) disable iff (rst)
    item.valid && phase == PH_CRC |=> $stable(running_crc))
    else $error("running crc changed while taking crc bytes");
`endif

endmodule

/* src/shfd_out_stage.sv */
// Result register: holds one result item until the downstream side takes it.
// Depends on shfd_pkg.
module shfd_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  shfd_pkg::result_t  res,
  input  logic               m_tready,
  output logic               m_tvalid,
  output shfd_pkg::result_t  res_q
);
  import shfd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

/* tb/sync_header_frame_deframer_crc16_core_tb.sv */
// Self-checking testbench for sync_header_frame_deframer_crc16_core.
// Streams received bytes with random gaps and back-pressure, predicts each result item
// from a local frame parser and CRC-16 model; depends on shfd_pkg for types and constants.
module sync_header_frame_deframer_crc16_core_tb;
  import shfd_pkg::*;

  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;

  typedef enum {FR_GOOD, FR_BAD_CRC, FR_TRUNC} frame_kind_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;         // [7:0] data_byte, [15:8] byte_index, [23:16] frame_type,
                                // [31:24] frame_seq, [39:32] payload_len, [55:40] crc_calculated
  logic [2:0]  m_tuser;         // [2:0] event_res
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  sync_header_frame_deframer_crc16_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // deframer model state
  logic [31:0] cfg_sync  = SYNC_RESET;
  logic [7:0]  cfg_max   = MAX_PAYLOAD_RESET;
  phase_t      fr_phase  = PH_HUNT;
  logic [1:0]  fr_count  = '0;
  logic [7:0]  fr_type   = '0;
  logic [7:0]  fr_seq    = '0;
  logic [7:0]  fr_len    = '0;
  logic [7:0]  pay_count = '0;
  logic [15:0] crc_acc   = CRC_INIT;
  logic [7:0]  crc_rx_lo = '0;

  result_t pending_results[$];
  int      errors        = 0;
  int      bytes_sent    = 0;
  int      settings_used = 1;
  int      ev_count[5]   = '{default: 0};
  bit      no_idle       = 1'b0;
  bit      hold_req      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [7:0] sync_at(input logic [1:0] k);
    logic [31:0] s;
    s = cfg_sync >> (8 * (3 - int'(k)));
    return s[7:0];
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10 && cfg_max != 8'hFF) return 8'($urandom_range(int'(cfg_max) + 1, 255));
    if (r < 13) return 8'($urandom_range(0, int'(cfg_max)));
    return 8'($urandom_range(0, (cfg_max < 8'd12) ? int'(cfg_max) : 12));
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic predict_deframe(input logic [7:0] b);
    result_t     r;
    logic [15:0] base;
    r = '0;
    r.event_res = EV_NONE;
    case (fr_phase)
      PH_HUNT: begin
        base = (fr_count == 2'd0) ? CRC_INIT : crc_acc;
        if (b == sync_at(fr_count)) begin
          crc_acc = crc16_update(base, b);
          if (fr_count == FC_LAST_SYNC) begin
            fr_count = '0;
            fr_phase = PH_HDR;
          end else begin
            fr_count = fr_count + 2'd1;
          end
        end else if (b == sync_at(2'd0)) begin
          crc_acc  = crc16_update(CRC_INIT, b);
          fr_count = 2'd1;
        end else begin
          crc_acc  = CRC_INIT;
          fr_count = '0;
        end
      end
      PH_HDR: begin
        crc_acc = crc16_update(crc_acc, b);
        if (fr_count == FC_TYPE) begin
          fr_type  = b;
          fr_count = FC_SEQ;
        end else if (fr_count == FC_SEQ) begin
          fr_seq   = b;
          fr_count = 2'd2;
        end else begin
          fr_len    = b;
          fr_count  = '0;
          pay_count = '0;
          if (b > cfg_max) begin
            r.event_res = EV_OVERSIZE;
            fr_phase    = PH_HUNT;
            crc_acc     = CRC_INIT;
          end else if (b == 8'd0) begin
            fr_phase = PH_CRC;
          end else begin
            fr_phase = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        crc_acc      = crc16_update(crc_acc, b);
        r.event_res  = EV_PAYLOAD;
        r.data_byte  = b;
        r.byte_index = pay_count;
        pay_count    = pay_count + 8'd1;
        if (pay_count >= fr_len || pay_count == 8'd0) begin
          fr_phase = PH_CRC;
          fr_count = '0;
        end
      end
      default: begin
        if (fr_count == 2'd0) begin
          crc_rx_lo = b;
          fr_count  = 2'd1;
        end else begin
          r.event_res = ({b, crc_rx_lo} == crc_acc) ? EV_GOOD : EV_CRC_ERR;
          fr_phase    = PH_HUNT;
          fr_count    = '0;
        end
      end
    endcase
    r.frame_type     = fr_type;
    r.frame_seq      = fr_seq;
    r.payload_len    = fr_len;
    r.crc_calculated = crc_acc;
    pending_results.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    predict_deframe(b);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] fseq,
                            input logic [7:0] flen, input frame_kind_t kind);
    logic [7:0]  frame[$];
    logic [15:0] crc;
    int          cut;
    for (int k = 0; k < 4; k++) frame.push_back(sync_at(2'(k)));
    frame.push_back(ftype);
    frame.push_back(fseq);
    frame.push_back(flen);
    if (flen <= cfg_max) begin
      for (int i = 0; i < int'(flen); i++) frame.push_back(rand_byte());
      crc = CRC_INIT;
      foreach (frame[i]) crc = crc16_update(crc, frame[i]);
      if (kind == FR_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
    end
    cut = (kind == FR_TRUNC) ? $urandom_range(1, frame.size() - 1) : frame.size();
    for (int i = 0; i < cut; i++) send_byte(frame[i]);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic check_reg(input logic idx);
    logic [31:0] want;
    want    = (idx == REG_SYNC) ? cfg_sync : {24'h0, cfg_max};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field(idx == REG_SYNC ? "sync_pattern[31:16]" : "max_payload",
                want[31:16] | (idx == REG_SYNC ? 16'h0 : want[15:0]),
                prdata[31:16] | (idx == REG_SYNC ? 16'h0 : prdata[15:0]));
    if (idx == REG_SYNC) check_field("sync_pattern[15:0]", want[15:0], prdata[15:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SYNC) cfg_sync = val;
    else cfg_max = val[7:0];
    @(posedge clk);
    check_reg(idx);
  endtask

  task automatic set_config(input logic [31:0] sync_val, input logic [7:0] max_val);
    wait_idle();
    write_reg(REG_SYNC, sync_val);
    write_reg(REG_MAX, {24'h0, max_val});
    settings_used++;
  endtask

  task automatic random_traffic(input int n);
    int stop_at;
    int r;
    int cnt;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame(rand_byte(), rand_byte(), pick_len(), FR_GOOD);
      end else if (r < 80) begin
        send_frame(rand_byte(), rand_byte(), pick_len(), FR_BAD_CRC);
      end else if (r < 86) begin
        send_frame(rand_byte(), rand_byte(), pick_len(), FR_TRUNC);
      end else if (r < 93) begin
        cnt = $urandom_range(1, 6);
        repeat (cnt) send_byte(rand_byte());
      end else begin
        cnt = $urandom_range(1, 3);
        for (int k = 0; k < cnt; k++) send_byte(sync_at(2'(k)));
        send_byte(rand_byte());
      end
    end
  endtask

  task automatic test_register_reset();
    check_reg(REG_SYNC);
    check_reg(REG_MAX);
  endtask

  task automatic test_directed();
    send_byte(8'h00);
    send_frame(8'hFF, 8'h00, 8'd0, FR_GOOD);
    // restart the hunt on a repeated first sync byte, then hit an oversize length
    repeat (4) send_byte(sync_at(2'd0));
    send_byte(sync_at(2'd2));
    send_byte(sync_at(2'd3));
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_frame(8'h00, 8'hFF, 8'd1, FR_BAD_CRC);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    no_idle  = 1'b1;
    repeat (3) send_frame(rand_byte(), rand_byte(), 8'd6, FR_GOOD);
    no_idle  = 1'b0;
  endtask

  task automatic test_config_sweep();
    set_config($urandom, 8'd4);
    random_traffic(120);
    set_config(32'h0000_0000, 8'd0);
    random_traffic(80);
    set_config(32'hFFFF_FFFF, 8'hFF);
    random_traffic(120);
    set_config(SYNC_RESET, MAX_PAYLOAD_RESET);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    random_traffic(100);
    no_idle = 1'b0;
  endtask

  // result sink: random stalls, plus a long hold-off on request
  initial begin : sink
    int g;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        g = pick_gap();
        if (g > 0 && !hold_req) begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no byte outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        ev_count[int'(want.event_res)]++;
        check_field("event_res", 16'(want.event_res), 16'(m_tuser));
        check_field("data_byte", 16'(want.data_byte), 16'(m_tdata[7:0]));
        check_field("byte_index", 16'(want.byte_index), 16'(m_tdata[15:8]));
        check_field("frame_type", 16'(want.frame_type), 16'(m_tdata[23:16]));
        check_field("frame_seq", 16'(want.frame_seq), 16'(m_tdata[31:24]));
        check_field("payload_len", 16'(want.payload_len), 16'(m_tdata[39:32]));
        check_field("crc_calculated", want.crc_calculated, m_tdata[55:40]);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_directed();
    random_traffic(200);
    test_backpressure();
    test_config_sweep();
    test_back_to_back();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes: %0d payload bytes, %0d good frames, %0d CRC errors, %0d oversize",
             bytes_sent, ev_count[int'(EV_PAYLOAD)], ev_count[int'(EV_GOOD)],
             ev_count[int'(EV_CRC_ERR)], ev_count[int'(EV_OVERSIZE)]);
    $display("Register settings used: %0d, incl. all-zero/all-one sync, max payload 0 and 255",
             settings_used);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
